/* src/jnp_pkg.sv */
// Package for the JSON nesting prescan: beat structs, status codes, byte codes.
// Used by jnp_scan and json_nesting_prescan.
`default_nettype none
package jnp_pkg;

   localparam int COUNT_WIDTH_DEF = 25;
   localparam int MAX_BYTES_W     = 24;
   localparam int DEPTH_W         = 6;
   localparam int ZRUN_W          = 3;

   localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RST = 24'd65536;
   localparam logic [DEPTH_W-1:0]     MAX_DEPTH_RST = 6'd20;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;

   localparam logic [ZRUN_W-1:0] ZRUN_IDLE  = 3'd0;
   localparam logic [ZRUN_W-1:0] ZRUN_START = 3'd1;
   localparam logic [ZRUN_W-1:0] ZRUN_FULL  = 3'd4;

   typedef enum logic [0:0] {
      CSR_MAX_BYTES = 1'b0,
      CSR_MAX_DEPTH = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_LONG    = 3'd1,
      ST_NUL_BYTE    = 3'd2,
      ST_TOO_DEEP    = 3'd3,
      ST_UNMATCHED   = 3'd4,
      ST_ESCAPED_NUL = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       accepted;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic [MAX_BYTES_W-1:0] max_bytes;
      logic [DEPTH_W-1:0]     max_depth;
   } cfg_type;

endpackage
`default_nettype wire

/* src/jnp_scan.sv */
// Scanner state and per-byte update for the JSON nesting prescan.
// Depends on jnp_pkg.
`default_nettype none
module jnp_scan
   import jnp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type beat,
   input  wire cfg_type cfg,
   output rsp_type      verdict
);

   localparam int CMP_W = (COUNT_WIDTH > MAX_BYTES_W) ? COUNT_WIDTH : MAX_BYTES_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   in_string_ff, in_string_in;
   logic                   after_bs_ff, after_bs_in;
   logic [DEPTH_W-1:0]     nest_ff, nest_in;
   logic [ZRUN_W-1:0]      zrun_ff, zrun_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   nul_ff, nul_in;
   status_type             err_ff, err_in;
   logic [DEPTH_W:0]       nest_up;
   logic                   too_long;

   always_comb begin
      in_string_in = in_string_ff;
      after_bs_in  = after_bs_ff;
      nest_in      = nest_ff;
      zrun_in      = zrun_ff;
      err_in       = err_ff;
      nest_up      = {1'b0, nest_ff} + {{DEPTH_W{1'b0}}, 1'b1};
      count_in     = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      nul_in       = nul_ff | (beat.text_byte == CH_NUL);

      if (err_ff == ST_OK) begin
         if (zrun_ff != ZRUN_IDLE && beat.text_byte == CH_ZERO && zrun_ff >= ZRUN_FULL) begin
            err_in = ST_ESCAPED_NUL;
         end else begin
            if (zrun_ff != ZRUN_IDLE) begin
               zrun_in = (beat.text_byte == CH_ZERO) ? zrun_ff + 1'b1 : ZRUN_IDLE;
            end
            if (in_string_ff) begin
               if (after_bs_ff) begin
                  if (beat.text_byte == CH_U) zrun_in = ZRUN_START;
                  after_bs_in = 1'b0;
               end else if (beat.text_byte == CH_BSLASH) begin
                  after_bs_in = 1'b1;
               end else if (beat.text_byte == CH_QUOTE) begin
                  in_string_in = 1'b0;
               end
            end else if (beat.text_byte == CH_QUOTE) begin
               in_string_in = 1'b1;
            end else if (beat.text_byte == CH_LBRACE || beat.text_byte == CH_LBRACK) begin
               if (nest_up > {1'b0, cfg.max_depth}) err_in = ST_TOO_DEEP;
               else nest_in = nest_up[DEPTH_W-1:0];
            end else if (beat.text_byte == CH_RBRACE || beat.text_byte == CH_RBRACK) begin
               if (nest_ff == '0) err_in = ST_UNMATCHED;
               else nest_in = nest_ff - 1'b1;
            end
         end
      end

      too_long = CMP_W'(count_in) > CMP_W'(cfg.max_bytes);
      if (too_long) verdict.status = ST_TOO_LONG;
      else if (nul_in) verdict.status = ST_NUL_BYTE;
      else verdict.status = err_in;
      verdict.accepted = (verdict.status == ST_OK);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && beat.last)) begin
         in_string_ff <= 1'b0;
         after_bs_ff  <= 1'b0;
         nest_ff      <= '0;
         zrun_ff      <= ZRUN_IDLE;
         count_ff     <= '0;
         nul_ff       <= 1'b0;
         err_ff       <= ST_OK;
      end else if (step) begin
         in_string_ff <= in_string_in;
         after_bs_ff  <= after_bs_in;
         nest_ff      <= nest_in;
         zrun_ff      <= zrun_in;
         count_ff     <= count_in;
         nul_ff       <= nul_in;
         err_ff       <= err_in;
      end
   end

endmodule
`default_nettype wire

/* src/json_nesting_prescan.sv */
// Top level of the JSON nesting prescan: beat register, config registers, result register.
// Depends on jnp_pkg and jnp_scan.
//
// Streams one JSON text per sequence of beats, one byte a beat, and returns one verdict
// beat for the beat marked last: accepted plus a status code (too long, then NUL byte,
// then the first scan error among too deep, unmatched close and escaped NUL).
// Throughput is one byte per clock unless the scanner stalls; a taken byte is held in
// the beat register for the scanner, and a final byte's verdict is registered in the
// result register, which drives rsp and holds a verdict while the next text streams in;
// the scanner stalls only when a final byte meets a verdict not yet taken.
// Write csr registers (0 max_bytes, 1 max_depth) only between texts.
`default_nettype none
module json_nesting_prescan
   import jnp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_beat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_beat,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire csr_index_type          csr_index,
   input  wire logic [MAX_BYTES_W-1:0] csr_data
);

   logic    s0_valid_ff;
   req_type s0_beat_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_beat_ff;
   cfg_type cfg_ff;
   rsp_type verdict;
   logic    out_free;
   logic    s0_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s0_fire   = s0_valid_ff && (!s0_beat_ff.last || out_free);
   assign req_ready = !s0_valid_ff || s0_fire;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   jnp_scan #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (s0_fire),
      .beat    (s0_beat_ff),
      .cfg     (cfg_ff),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_bytes <= MAX_BYTES_RST;
         cfg_ff.max_depth <= MAX_DEPTH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_BYTES: cfg_ff.max_bytes <= csr_data;
            CSR_MAX_DEPTH: cfg_ff.max_depth <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s0_beat_ff <= req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s0_fire && s0_beat_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s0_fire && s0_beat_ff.last) begin
         rsp_beat_ff <= verdict;
      end
   end

endmodule
`default_nettype wire

/* dv/json_nesting_prescan_tb.sv */
// Self-checking bench for json_nesting_prescan: streams JSON texts byte by byte,
// predicts each verdict in a scoreboard, and checks every rsp beat field by field.
// Depends on jnp_pkg and the json_nesting_prescan RTL.
`timescale 1ns / 1ps

module json_nesting_prescan_tb;
   import jnp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_BYTES  = 225;
   localparam int PHASE_COUNT  = 7;
   localparam int SETTLE_WAIT  = 4;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_beat  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_beat;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_MAX_BYTES;
   logic [MAX_BYTES_W-1:0] csr_data  = '0;

   json_nesting_prescan dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // scanner copy: limits and per-text state
   logic [MAX_BYTES_W-1:0]     lim_bytes = MAX_BYTES_RST;
   logic [DEPTH_W-1:0]         lim_depth = MAX_DEPTH_RST;
   logic                       in_str    = 1'b0;
   logic                       esc       = 1'b0;
   logic [DEPTH_W-1:0]         depth     = '0;
   logic [ZRUN_W-1:0]          zrun      = ZRUN_IDLE;
   logic [COUNT_WIDTH_DEF-1:0] txt_len   = '0;
   logic                       saw_nul   = 1'b0;
   status_type                 first_err = ST_OK;

   req_type    pending_bytes[$];
   rsp_type    verdicts[$];
   logic [7:0] text_buf[$];
   rsp_type    due;

   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_calls    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int phase_bytes   = 0;
   int mismatches    = 0;
   int cycles        = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      mismatches++;
   endtask

   task automatic scan_text_byte(input logic [7:0] b);
      int unsigned deeper;
      if (first_err != ST_OK) return;
      if (zrun != ZRUN_IDLE) begin
         if (b == CH_ZERO) begin
            if (zrun >= ZRUN_FULL) begin
               first_err = ST_ESCAPED_NUL;
               return;
            end
            zrun = zrun + 1'b1;
         end else begin
            zrun = ZRUN_IDLE;
         end
      end
      if (in_str) begin
         if (esc) begin
            if (b == CH_U) zrun = ZRUN_START;
            esc = 1'b0;
         end else if (b == CH_BSLASH) begin
            esc = 1'b1;
         end else if (b == CH_QUOTE) begin
            in_str = 1'b0;
         end
      end else if (b == CH_QUOTE) begin
         in_str = 1'b1;
      end else if (b == CH_LBRACE || b == CH_LBRACK) begin
         deeper = depth + 1;
         if (deeper > lim_depth) first_err = ST_TOO_DEEP;
         else depth = deeper[DEPTH_W-1:0];
      end else if (b == CH_RBRACE || b == CH_RBRACK) begin
         if (depth == 0) first_err = ST_UNMATCHED;
         else depth = depth - 1'b1;
      end
   endtask

   task automatic take_text_byte(input req_type beat);
      rsp_type    verdict;
      status_type st;
      if (txt_len != '1) txt_len = txt_len + 1'b1;
      if (beat.text_byte == CH_NUL) saw_nul = 1'b1;
      scan_text_byte(beat.text_byte);
      if (beat.last) begin
         if (txt_len > lim_bytes) st = ST_TOO_LONG;
         else if (saw_nul) st = ST_NUL_BYTE;
         else st = first_err;
         verdict.accepted = (st == ST_OK);
         verdict.status   = st;
         verdicts.push_back(verdict);
         in_str    = 1'b0;
         esc       = 1'b0;
         depth     = '0;
         zrun      = ZRUN_IDLE;
         txt_len   = '0;
         saw_nul   = 1'b0;
         first_err = ST_OK;
      end
   endtask

   // text builders
   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   task automatic put_unicode();
      int zeros;
      int k;
      put_str("\\u");
      zeros = $urandom_range(5);
      for (k = 0; k < zeros; k++) text_buf.push_back(CH_ZERO);
      for (k = zeros; k < 4; k++) begin
         if ($urandom_range(1)) text_buf.push_back(8'(8'h30 + $urandom_range(9)));
         else text_buf.push_back(8'(8'h61 + $urandom_range(5)));
      end
   endtask

   task automatic put_string_lit();
      int n;
      text_buf.push_back(CH_QUOTE);
      n = $urandom_range(6);
      repeat (n) begin
         case ($urandom_range(7))
            0: put_str("\\\"");
            1: put_str("\\\\");
            2: put_unicode();
            3: text_buf.push_back(8'($urandom_range(8'h7e, 8'h20)));
            4: text_buf.push_back($urandom_range(1) ? CH_LBRACK : CH_RBRACE);
            default: text_buf.push_back(8'($urandom_range(8'h7a, 8'h61)));
         endcase
      end
      text_buf.push_back(CH_QUOTE);
   endtask

   task automatic put_value();
      case ($urandom_range(5))
         0: put_str("1");
         1: put_str("true,");
         2: put_str(" null : ");
         3: put_str("-0.25e3");
         default: put_string_lit();
      endcase
   endtask

   task automatic put_nested(input int levels);
      int k;
      for (k = 0; k < levels; k++) begin
         text_buf.push_back($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
         if ($urandom_range(2) == 0) put_value();
      end
      if (levels == 0 || $urandom_range(1)) put_value();
      for (k = 0; k < levels; k++) begin
         text_buf.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
         if (k != levels - 1 && $urandom_range(3) == 0) put_str(",");
      end
   endtask

   task automatic queue_text();
      req_type beat;
      if (text_buf.size() == 0) put_str("0");
      foreach (text_buf[i]) begin
         beat.text_byte = text_buf[i];
         beat.last      = (i == text_buf.size() - 1);
         pending_bytes.push_back(beat);
      end
      phase_bytes += text_buf.size();
      text_buf.delete();
   endtask

   task automatic gen_text();
      int r;
      int levels;
      int k;
      r = $urandom_range(99);
      if ($urandom_range(7) == 0 && lim_depth <= 12) levels = lim_depth + $urandom_range(1);
      else levels = $urandom_range(4);
      if (r < 55) begin
         put_nested(levels);
      end else if (r < 75) begin
         put_nested(levels);
         case ($urandom_range(3))
            0: text_buf.insert($urandom_range(text_buf.size()),
                               $urandom_range(1) ? CH_RBRACE : CH_RBRACK);
            1: begin
               k = $urandom_range(text_buf.size(), 1);
               text_buf = text_buf[0:k-1];
            end
            2: text_buf.insert($urandom_range(text_buf.size()), CH_NUL);
            default: text_buf.insert($urandom_range(text_buf.size()), 8'($urandom_range(255)));
         endcase
      end else if (r < 87) begin
         text_buf.push_back(CH_QUOTE);
         case ($urandom_range(3))
            0: put_str("\\\\u0000");
            1: put_unicode();
            2: put_str("\\u\\u0000");
            default: put_str("u0000");
         endcase
         if ($urandom_range(1)) text_buf.push_back(CH_QUOTE);
      end else begin
         k = $urandom_range(10, 1);
         repeat (k) text_buf.push_back(8'($urandom_range(255)));
      end
      queue_text();
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [MAX_BYTES_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_BYTES) lim_bytes = val;
      else lim_depth = val[DEPTH_W-1:0];
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_bytes.size() != 0 || req_valid || verdicts.size() != 0)
             && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) take_text_byte(req_beat);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               req_valid <= 1'b1;
               req_beat  <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, with an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_calls) begin
         hold_seen <= hold_calls;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts.size() == 0) begin
            report_mismatch("verdict beat with none pending", int'(rsp_beat.status), -1);
         end else begin
            due = verdicts.pop_front();
            if (rsp_beat.accepted !== due.accepted)
               report_mismatch("accepted", int'(rsp_beat.accepted), int'(due.accepted));
            if (rsp_beat.status !== due.status)
               report_mismatch("status", int'(rsp_beat.status), int'(due.status));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph % 3)
            0: begin
               req_gap_pct   = 35;
               rsp_stall_pct = 75;
            end
            1: begin
               req_gap_pct   = 75;
               rsp_stall_pct = 35;
            end
            default: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
         endcase
         case (ph)
            1: begin
               write_csr(CSR_MAX_BYTES, 24'hFFFFFF);
               write_csr(CSR_MAX_DEPTH, 24'd62);
            end
            2: begin
               write_csr(CSR_MAX_BYTES, 24'd1);
               write_csr(CSR_MAX_DEPTH, 24'd1);
            end
            3: begin
               write_csr(CSR_MAX_BYTES, 24'd12);
               write_csr(CSR_MAX_DEPTH, 24'd3);
            end
            4: begin
               write_csr(CSR_MAX_BYTES, 24'($urandom_range(40, 6)));
               write_csr(CSR_MAX_DEPTH, 24'd0);
            end
            5: begin
               write_csr(CSR_MAX_BYTES, 24'($urandom_range(200, 1)));
               write_csr(CSR_MAX_DEPTH, {18'($urandom), 6'($urandom_range(62, 1))});
            end
            6: begin
               write_csr(CSR_MAX_BYTES, MAX_BYTES_RST);
               write_csr(CSR_MAX_DEPTH, 24'(MAX_DEPTH_RST));
            end
            default: begin
               put_str("[]");
               queue_text();
               put_str("\"\\u0000\"");
               queue_text();
               put_str("1");
               queue_text();
               text_buf.push_back(CH_NUL);
               queue_text();
               put_str("]");
               queue_text();
               text_buf.push_back(8'hFF);
               queue_text();
               put_str("\"]\"");
               queue_text();
               put_str("\"\\u000");
               queue_text();
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) gen_text();
         if (ph % 3 == 2) hold_calls <= hold_calls + 1;
         drain();
      end
      drain();
      if (verdicts.size() != 0)
         report_mismatch("verdicts never returned", verdicts.size(), 0);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
